// File: rtl/soft_cpu_instruction_execute_macros.svh
// assertion macros shared by the soft cpu execute block
`ifndef SOFT_CPU_INSTRUCTION_EXECUTE_MACROS_SVH
`define SOFT_CPU_INSTRUCTION_EXECUTE_MACROS_SVH

// same-cycle implication, clocked on clk, disabled during reset
`define SCIE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, disabled during reset
`define SCIE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/scie_pkg.sv
// types, codes and helpers of the soft cpu execute block
package scie_pkg;

    localparam int NUM_REGS_DEF    = 32;
    localparam int STACK_DEPTH_DEF = 31;
    localparam int PC_BITS_DEF     = 10;

    typedef struct packed {
        logic [17:0] instr;
        logic [7:0]  in_data;
    } in_t;

    typedef struct packed {
        logic [9:0] next_pc;
        logic [7:0] port_id;
        logic [7:0] out_data;
        logic       write_strobe;
        logic       read_strobe;
        logic       carry_flag;
        logic       zero_flag;
        logic       int_enable;
        logic [1:0] error_code;
    } out_t;

    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_INVALID = 2'd1,
        ERR_RETURN  = 2'd2
    } err_t;

    // state changes requested by one instruction
    typedef struct packed {
        logic       rf_we;
        logic [7:0] rf_wdata;
        logic       carry;
        logic       zero;
        logic       ie;
        logic       push;
        logic       pop;
        logic       oc_inc;
        logic       oc_dec;
    } upd_t;

    localparam logic [4:0] GRP_INPUT_K  = 5'd16;
    localparam logic [4:0] GRP_OUTPUT_K = 5'd17;
    localparam logic [4:0] GRP_RETURN   = 5'd18;
    localparam logic [4:0] GRP_SHIFT    = 5'd20;
    localparam logic [4:0] GRP_RETI     = 5'd22;
    localparam logic [4:0] GRP_INPUT_R  = 5'd24;
    localparam logic [4:0] GRP_OUTPUT_R = 5'd25;
    localparam logic [4:0] GRP_JUMP     = 5'd26;
    localparam logic [4:0] GRP_CALL     = 5'd27;
    localparam logic [4:0] GRP_INTCTL   = 5'd30;

    localparam logic [2:0] OP_LOAD  = 3'd0;
    localparam logic [2:0] OP_AND   = 3'd1;
    localparam logic [2:0] OP_OR    = 3'd2;
    localparam logic [2:0] OP_XOR   = 3'd3;
    localparam logic [2:0] OP_ADD   = 3'd4;
    localparam logic [2:0] OP_ADDCY = 3'd5;
    localparam logic [2:0] OP_SUB   = 3'd6;
    localparam logic [2:0] OP_SUBCY = 3'd7;

    localparam logic [2:0] COND_Z  = 3'd4;
    localparam logic [2:0] COND_NZ = 3'd5;
    localparam logic [2:0] COND_C  = 3'd6;
    localparam logic [2:0] COND_NC = 3'd7;

    localparam logic [7:0] SH_SRA = 8'h08;
    localparam logic [7:0] SH_SRX = 8'h0a;
    localparam logic [7:0] SH_RR  = 8'h0c;
    localparam logic [7:0] SH_SR0 = 8'h0e;
    localparam logic [7:0] SH_SR1 = 8'h0f;
    localparam logic [7:0] SH_SLA = 8'h00;
    localparam logic [7:0] SH_RL  = 8'h02;
    localparam logic [7:0] SH_SLX = 8'h04;
    localparam logic [7:0] SH_SL0 = 8'h06;
    localparam logic [7:0] SH_SL1 = 8'h07;

    localparam logic [17:0] W_RETI_EN  = 18'h2C001;
    localparam logic [17:0] W_RETI_DIS = 18'h2C000;
    localparam logic [17:0] W_INT_EN   = 18'h3C001;
    localparam logic [17:0] W_INT_DIS  = 18'h3C000;

    localparam logic [7:0] OC_MAX = 8'hff;

    // register field reduced modulo the register count, n at least 8
    function automatic logic [4:0] reg_mod(input logic [4:0] idx, input int n);
        logic [5:0] v;
        logic [5:0] nn;
        v  = {1'b0, idx};
        nn = 6'(n);
        for (int i = 0; i < 4; i++) begin
            if (v >= nn) begin
                v = v - nn;
            end
        end
        return v[4:0];
    endfunction

endpackage

// File: rtl/scie_regfile.sv
// byte register file with two registered read ports and write forwarding
module scie_regfile
    import scie_pkg::*;
#(
    parameter int NUM_REGS = NUM_REGS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rd_en,
    input  logic [4:0] ra_addr,
    input  logic [4:0] rb_addr,
    input  logic       we,
    input  logic [4:0] waddr,
    input  logic [7:0] wdata,
    output logic [7:0] ra_data,
    output logic [7:0] rb_data
);

    localparam int RI_W = $clog2(NUM_REGS);

    logic [7:0]          mem [NUM_REGS];
    logic [NUM_REGS-1:0] vld_reg;
    logic [7:0]          ra_reg;
    logic [7:0]          rb_reg;
    logic [4:0]          ra_m;
    logic [4:0]          rb_m;
    logic [4:0]          w_m;
    logic [RI_W-1:0]     ai;
    logic [RI_W-1:0]     bi;
    logic [RI_W-1:0]     wi;

    assign ra_m = reg_mod(ra_addr, NUM_REGS);
    assign rb_m = reg_mod(rb_addr, NUM_REGS);
    assign w_m  = reg_mod(waddr, NUM_REGS);
    assign ai   = ra_m[RI_W-1:0];
    assign bi   = rb_m[RI_W-1:0];
    assign wi   = w_m[RI_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (we)
        begin
            vld_reg[wi] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wi] <= wdata;
        end
    end

    // an entry never written reads as zero
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            ra_reg <= (we && wi == ai) ? wdata : (vld_reg[ai] ? mem[ai] : 8'h00);
            rb_reg <= (we && wi == bi) ? wdata : (vld_reg[bi] ? mem[bi] : 8'h00);
        end
    end

    assign ra_data = ra_reg;
    assign rb_data = rb_reg;

endmodule

// File: rtl/scie_exec.sv
// instruction decode, alu, shifter, branch and port logic
module scie_exec
    import scie_pkg::*;
#(
    parameter int PC_BITS = PC_BITS_DEF
) (
    input  logic [17:0]        instr,
    input  logic [7:0]         in_data,
    input  logic [7:0]         a,
    input  logic [7:0]         b,
    input  logic [PC_BITS-1:0] pc,
    input  logic [PC_BITS-1:0] pop_pc,
    input  logic               carry,
    input  logic               zero,
    input  logic               ie,
    input  logic               oc_zero,
    output logic [PC_BITS-1:0] pc_next,
    output upd_t               upd,
    output out_t               res
);

    logic [4:0]         group;
    logic [2:0]         op;
    logic [7:0]         kk;
    logic [7:0]         opnd;
    logic [8:0]         alu_r;
    logic [7:0]         sh_r;
    logic               sh_c;
    logic               sh_ok;
    logic               cond;
    logic [PC_BITS-1:0] pc_inc;
    logic [PC_BITS-1:0] target;
    err_t               err;

    assign group  = instr[17:13];
    assign op     = group[2:0];
    assign kk     = instr[7:0];
    assign opnd   = group[3] ? b : kk;
    assign pc_inc = pc + PC_BITS'(1);
    assign target = instr[PC_BITS-1:0];

    always_comb
    begin
        case (instr[12:10])
            COND_Z:  cond = zero;
            COND_NZ: cond = !zero;
            COND_C:  cond = carry;
            COND_NC: cond = !carry;
            default: cond = 1'b1;
        endcase
    end

    always_comb
    begin
        case (op)
            OP_AND:   alu_r = {1'b0, a & opnd};
            OP_OR:    alu_r = {1'b0, a | opnd};
            OP_XOR:   alu_r = {1'b0, a ^ opnd};
            OP_ADD:   alu_r = {1'b0, a} + {1'b0, opnd};
            OP_ADDCY: alu_r = {1'b0, a} + {1'b0, opnd} + {8'h00, carry};
            OP_SUB:   alu_r = {1'b0, a} - {1'b0, opnd};
            OP_SUBCY: alu_r = {1'b0, a} - {1'b0, opnd} - {8'h00, carry};
            default:  alu_r = {1'b0, opnd};
        endcase
    end

    always_comb
    begin
        sh_ok = 1'b1;
        case (kk)
            SH_SRA:
            begin
                sh_c = a[0];
                sh_r = {carry, a[7:1]};
            end
            SH_SRX:
            begin
                sh_c = a[0];
                sh_r = {a[7], a[7:1]};
            end
            SH_RR:
            begin
                sh_c = a[0];
                sh_r = {a[0], a[7:1]};
            end
            SH_SR0:
            begin
                sh_c = a[0];
                sh_r = {1'b0, a[7:1]};
            end
            SH_SR1:
            begin
                sh_c = a[0];
                sh_r = {1'b1, a[7:1]};
            end
            SH_SLA:
            begin
                sh_c = a[7];
                sh_r = {a[6:0], carry};
            end
            SH_RL:
            begin
                sh_c = a[7];
                sh_r = {a[6:0], a[7]};
            end
            SH_SLX:
            begin
                sh_c = a[7];
                sh_r = {a[6:0], a[0]};
            end
            SH_SL0:
            begin
                sh_c = a[7];
                sh_r = {a[6:0], 1'b0};
            end
            SH_SL1:
            begin
                sh_c = a[7];
                sh_r = {a[6:0], 1'b1};
            end
            default:
            begin
                sh_ok = 1'b0;
                sh_c  = carry;
                sh_r  = a;
            end
        endcase
    end

    always_comb
    begin
        upd              = '0;
        upd.carry        = carry;
        upd.zero         = zero;
        upd.ie           = ie;
        pc_next          = pc_inc;
        err              = ERR_NONE;
        res              = '0;
        if (!group[4])
        begin
            upd.rf_we    = 1'b1;
            upd.rf_wdata = alu_r[7:0];
            if (op != OP_LOAD)
            begin
                upd.carry = op[2] ? alu_r[8] : 1'b0;
                upd.zero  = (alu_r[7:0] == 8'h00);
            end
        end
        else
        begin
            case (group)
                GRP_INPUT_K, GRP_INPUT_R:
                begin
                    res.port_id     = opnd;
                    res.read_strobe = 1'b1;
                    upd.rf_we       = 1'b1;
                    upd.rf_wdata    = in_data;
                end
                GRP_OUTPUT_K, GRP_OUTPUT_R:
                begin
                    res.port_id      = opnd;
                    res.out_data     = a;
                    res.write_strobe = 1'b1;
                end
                GRP_RETURN:
                begin
                    if (instr[9:0] != 10'd0)
                    begin
                        err = ERR_INVALID;
                    end
                    else if (cond)
                    begin
                        if (oc_zero)
                        begin
                            err = ERR_RETURN;
                        end
                        else
                        begin
                            upd.oc_dec = 1'b1;
                        end
                        upd.pop = 1'b1;
                        pc_next = pop_pc;
                    end
                end
                GRP_SHIFT:
                begin
                    if (sh_ok)
                    begin
                        upd.carry    = sh_c;
                        upd.zero     = (sh_r == 8'h00);
                        upd.rf_we    = 1'b1;
                        upd.rf_wdata = sh_r;
                    end
                    else
                    begin
                        err = ERR_INVALID;
                    end
                end
                GRP_RETI:
                begin
                    if (instr == W_RETI_EN || instr == W_RETI_DIS)
                    begin
                        upd.ie  = instr[0];
                        upd.pop = 1'b1;
                        pc_next = pop_pc;
                    end
                    else
                    begin
                        err = ERR_INVALID;
                    end
                end
                GRP_JUMP:
                begin
                    if (cond)
                    begin
                        pc_next = target;
                    end
                end
                GRP_CALL:
                begin
                    if (cond)
                    begin
                        upd.push   = 1'b1;
                        upd.oc_inc = 1'b1;
                        pc_next    = target;
                    end
                end
                GRP_INTCTL:
                begin
                    if (instr == W_INT_EN || instr == W_INT_DIS)
                    begin
                        upd.ie = instr[0];
                    end
                    else
                    begin
                        err = ERR_INVALID;
                    end
                end
                default:
                begin
                    err = ERR_INVALID;
                end
            endcase
        end
        res.next_pc    = 10'(pc_next);
        res.carry_flag = upd.carry;
        res.zero_flag  = upd.zero;
        res.int_enable = upd.ie;
        res.error_code = err;
    end

endmodule

// File: rtl/soft_cpu_instruction_execute.sv
// top level of the soft cpu instruction execute block
//
// in_item carries one instruction word and the input port byte per beat,
// out_item carries the resulting program counter, port signals, flags and
// an error code; both channels use valid and ready.
// a beat accepted into the input register executes there and its result is
// registered in the output register once that register is free or being
// taken; register operands are read at the accept edge, execute runs while
// the beat sits in the input register.
// throughput: one instruction per cycle sustained while out_ready stays high;
// flags, program counter and return stack are read and written in the
// execute cycle, register operands are read at acceptance with the write of
// the instruction that executes at that same edge forwarded.
// when the receiver stalls the result holds in the output register and one
// more beat waits in the input register; in_ready drops only when both
// are full.
// reset clears the program counter, flags, return stack, stack pointer,
// open call count and register valid bits; registers read as zero until
// written, and both channels come up empty.
`include "soft_cpu_instruction_execute_macros.svh"

module soft_cpu_instruction_execute
    import scie_pkg::*;
#(
    parameter int NUM_REGS    = NUM_REGS_DEF,
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int PC_BITS     = PC_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  in_t  in_item,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_item
);

    localparam int SP_W = $clog2(STACK_DEPTH);

    logic               s1_vld_reg;
    in_t                s1_item_reg;
    logic               o_vld_reg;
    logic               o_vld_next;
    out_t               o_item_reg;
    logic [PC_BITS-1:0] pc_reg;
    logic [PC_BITS-1:0] pc_next;
    logic               carry_reg;
    logic               zero_reg;
    logic               ie_reg;
    logic [7:0]         oc_reg;
    logic [7:0]         oc_next;
    logic [SP_W-1:0]    sp_reg;
    logic [SP_W-1:0]    sp_next;
    logic [SP_W-1:0]    pop_idx;
    logic [PC_BITS-1:0] stack_reg [STACK_DEPTH];
    logic [PC_BITS-1:0] ex_pc;
    logic [7:0]         ra;
    logic [7:0]         rb;
    logic               accept;
    logic               fire;
    upd_t               upd;
    out_t               res;

    assign fire     = s1_vld_reg && (!o_vld_reg || out_ready);
    assign in_ready = !s1_vld_reg || fire;
    assign accept   = in_valid && in_ready;

    scie_regfile #(
        .NUM_REGS (NUM_REGS)
    ) u_regfile (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .ra_addr (in_item.instr[12:8]),
        .rb_addr (in_item.instr[7:3]),
        .we      (fire && upd.rf_we),
        .waddr   (s1_item_reg.instr[12:8]),
        .wdata   (upd.rf_wdata),
        .ra_data (ra),
        .rb_data (rb)
    );

    assign pop_idx = (sp_reg == '0) ? SP_W'(STACK_DEPTH - 1) : sp_reg - SP_W'(1);

    scie_exec #(
        .PC_BITS (PC_BITS)
    ) u_exec (
        .instr   (s1_item_reg.instr),
        .in_data (s1_item_reg.in_data),
        .a       (ra),
        .b       (rb),
        .pc      (pc_reg),
        .pop_pc  (stack_reg[pop_idx]),
        .carry   (carry_reg),
        .zero    (zero_reg),
        .ie      (ie_reg),
        .oc_zero (oc_reg == 8'h00),
        .pc_next (ex_pc),
        .upd     (upd),
        .res     (res)
    );

    always_comb
    begin
        pc_next    = pc_reg;
        oc_next    = oc_reg;
        sp_next    = sp_reg;
        o_vld_next = o_vld_reg && !out_ready;
        if (fire)
        begin
            pc_next    = ex_pc;
            o_vld_next = 1'b1;
            if (upd.oc_inc && oc_reg != OC_MAX)
            begin
                oc_next = oc_reg + 8'd1;
            end
            else if (upd.oc_dec)
            begin
                oc_next = oc_reg - 8'd1;
            end
            if (upd.push)
            begin
                sp_next = (sp_reg == SP_W'(STACK_DEPTH - 1)) ? '0 : sp_reg + SP_W'(1);
            end
            else if (upd.pop)
            begin
                sp_next = pop_idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            o_vld_reg  <= 1'b0;
            pc_reg     <= '0;
            carry_reg  <= 1'b0;
            zero_reg   <= 1'b0;
            ie_reg     <= 1'b0;
            oc_reg     <= 8'h00;
            sp_reg     <= '0;
            for (int i = 0; i < STACK_DEPTH; i++)
            begin
                stack_reg[i] <= '0;
            end
        end
        else
        begin
            s1_vld_reg <= accept || (s1_vld_reg && !fire);
            o_vld_reg  <= o_vld_next;
            pc_reg     <= pc_next;
            oc_reg     <= oc_next;
            sp_reg     <= sp_next;
            if (fire)
            begin
                carry_reg <= upd.carry;
                zero_reg  <= upd.zero;
                ie_reg    <= upd.ie;
                if (upd.push)
                begin
                    stack_reg[sp_reg] <= pc_reg + PC_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= in_item;
        end
        if (fire)
        begin
            o_item_reg <= res;
        end
    end

    assign out_valid = o_vld_reg;
    assign out_item  = o_item_reg;

    `SCIE_ASSERT_NEXT(a_fire_gives_result, fire, o_vld_reg, "executed beat left no result")
    `SCIE_ASSERT_NOW(a_stall_only_when_full, !in_ready, s1_vld_reg && o_vld_reg && !out_ready,
        "input stalled while a stage is free")
    `SCIE_ASSERT_NEXT(a_call_counts, fire && upd.push, oc_reg != 8'h00,
        "open call count zero after a call")
    `SCIE_ASSERT_NOW(a_err_code_range, out_valid, out_item.error_code != 2'd3,
        "undefined error code on output")

endmodule
